// File: sv/warp_barrier_unit_assert.svh
// Assertion macros used by the warp barrier unit front end.
`ifndef WARP_BARRIER_UNIT_ASSERT_SVH
`define WARP_BARRIER_UNIT_ASSERT_SVH

// Condition and consequence checked on the same clock edge.
`define WBU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("warp barrier unit check failed");

// Consequence checked on the clock edge after the condition.
`define WBU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("warp barrier unit check failed");

`endif

// File: sv/wbu_pkg.sv
// Shared field widths, beat layouts and control structs of the warp barrier unit.
package wbu_pkg;

    // Field widths of the stream beats
    localparam int BAR_ID_W     = 3;
    localparam int EXP_W        = 4;
    localparam int WARP_W       = 3;
    localparam int PC_FIELD_W   = 32;
    localparam int MASK_FIELD_W = 8;

    // Widest slot index over the allowed warp counts
    localparam int SLOT_MAX_W   = 6;

    localparam int IN_FIELDS_W  = 58;
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_FIELDS_W = 43;
    localparam int OUT_TDATA_W  = 48;

    // Release queue depth
    localparam int RQ_DEPTH     = 2;
    localparam int RQ_AW        = 1;

    // Input beat, last field in the lowest bits
    typedef struct packed {
        logic [MASK_FIELD_W-1:0] predicate_mask;
        logic [MASK_FIELD_W-1:0] active_mask;
        logic [PC_FIELD_W-1:0]   warp_pc;
        logic [WARP_W-1:0]       warp_number;
        logic [EXP_W-1:0]        expected_count;
        logic [BAR_ID_W-1:0]     barrier_id;
    } t_in_item;

    // Stored warp record, laid out as the output beat
    typedef struct packed {
        logic [MASK_FIELD_W-1:0] released_mask;
        logic [PC_FIELD_W-1:0]   released_pc;
        logic [WARP_W-1:0]       released_warp;
    } t_warp_rec;

    // Slot store write from the front end
    typedef struct packed {
        logic                  en;
        logic [BAR_ID_W-1:0]   bar;
        logic [SLOT_MAX_W-1:0] slot;
        t_warp_rec             rec;
    } t_slot_wr;

    // Release job: barrier and its final filled slot
    typedef struct packed {
        logic [BAR_ID_W-1:0]   bar;
        logic [SLOT_MAX_W-1:0] last_slot;
    } t_rel_cmd;

    // Release finished for a barrier
    typedef struct packed {
        logic                en;
        logic [BAR_ID_W-1:0] bar;
    } t_rel_done;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND
    } t_back_state;

endpackage

// File: sv/wbu_front.sv
// Front end: takes arrivals, classifies them, keeps barrier counts and queues releases.
`include "warp_barrier_unit_assert.svh"

module wbu_front #(
    parameter int NUM_BARRIERS = 8,
    parameter int NUM_WARPS    = 8,
    parameter int NUM_LANES    = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [wbu_pkg::IN_TDATA_W-1:0] i_s_tdata,
    output wbu_pkg::t_slot_wr              o_wr,
    output logic                           o_push,
    output wbu_pkg::t_rel_cmd              o_push_cmd,
    input  logic                           i_q_full,
    input  wbu_pkg::t_rel_done             i_done
);

    localparam int BAR_LIM = 1 << wbu_pkg::BAR_ID_W;
    localparam int BAR_N   = (NUM_BARRIERS < BAR_LIM) ? NUM_BARRIERS : BAR_LIM;
    localparam int BAR_AW  = (BAR_N > 1) ? $clog2(BAR_N) : 1;
    localparam int CNT_W   = $clog2(NUM_WARPS);
    localparam int LANE_N  = (NUM_LANES < wbu_pkg::MASK_FIELD_W) ? NUM_LANES
                                                                  : wbu_pkg::MASK_FIELD_W;
    localparam int CMP_W   = (CNT_W > wbu_pkg::EXP_W) ? CNT_W : wbu_pkg::EXP_W;
    localparam logic [wbu_pkg::MASK_FIELD_W-1:0] LANE_KEEP =
        wbu_pkg::MASK_FIELD_W'((64'd1 << LANE_N) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(NUM_WARPS - 1);

    logic                r_in_valid;
    wbu_pkg::t_in_item   r_item;
    logic [BAR_N-1:0]    r_in_use;
    logic [BAR_N-1:0]    r_pending;
    logic [CNT_W-1:0]    r_count [BAR_N];

    logic [wbu_pkg::MASK_FIELD_W-1:0] act_kept;
    logic [wbu_pkg::EXP_W-1:0]        exp_m1;
    logic [BAR_AW-1:0]                bar;
    logic [CNT_W-1:0]                 cur;
    logic [CNT_W-1:0]                 cnt_next;
    logic                             take;
    logic                             fill;
    logic                             stall;
    logic                             commit;

    // Classify the held arrival
    always_comb begin
        act_kept = r_item.active_mask & LANE_KEEP;
        take     = (|(act_kept & r_item.predicate_mask)) &&
                   ({1'b0, r_item.barrier_id} < (wbu_pkg::BAR_ID_W + 1)'(BAR_N));
        bar      = r_item.barrier_id[BAR_AW-1:0];
        cur      = r_in_use[bar] ? r_count[bar] : '0;
        cnt_next = (cur == CNT_TOP) ? '0 : cur + 1'b1;
        exp_m1   = r_item.expected_count - 1'b1;
        fill     = (r_item.expected_count == wbu_pkg::EXP_W'(1)) ||
                   ((r_item.expected_count != '0) && (CMP_W'(cur) == CMP_W'(exp_m1)));
        // hold while this barrier is still being released, or no room for the job
        stall    = take && (r_pending[bar] || (fill && i_q_full));
        commit   = r_in_valid && !stall;
    end

    assign o_s_tready = !r_in_valid || commit;

    // Slot write and release job
    always_comb begin
        o_wr.en                = commit && take;
        o_wr.bar               = r_item.barrier_id;
        o_wr.slot              = wbu_pkg::SLOT_MAX_W'(cur);
        o_wr.rec.released_warp = r_item.warp_number;
        o_wr.rec.released_pc   = r_item.warp_pc;
        o_wr.rec.released_mask = act_kept;
        o_push                 = commit && take && fill;
        o_push_cmd.bar         = r_item.barrier_id;
        o_push_cmd.last_slot   = wbu_pkg::SLOT_MAX_W'(cur);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_use   <= '0;
            r_pending  <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (o_wr.en) begin
                r_in_use[bar] <= !fill;
            end
            if (o_push) begin
                r_pending[bar] <= 1'b1;
            end
            if (i_done.en) begin
                r_pending[i_done.bar[BAR_AW-1:0]] <= 1'b0;
            end
        end
    end

    // Held beat and arrival counts
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= wbu_pkg::t_in_item'(i_s_tdata[wbu_pkg::IN_FIELDS_W-1:0]);
        end
        if (o_wr.en && !fill) begin
            r_count[bar] <= cnt_next;
        end
    end

    // A barrier under release takes no new slot writes
    `WBU_ASSERT_NOW(a_wr_not_pending, o_wr.en, !r_pending[bar])
    // A barrier is never both collecting and releasing
    `WBU_ASSERT_NOW(a_use_pend_excl, 1'b1, (r_in_use & r_pending) == '0)
    // A finished release always belongs to a pending barrier
    `WBU_ASSERT_NOW(a_done_pending, i_done.en, r_pending[i_done.bar[BAR_AW-1:0]])
    // A queued release leaves at least one barrier pending
    `WBU_ASSERT_NEXT(a_push_marks, o_push, r_pending != '0)

endmodule

// File: sv/wbu_queue.sv
// Short queue of release jobs between the front and back ends.
module wbu_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wbu_pkg::t_rel_cmd i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output wbu_pkg::t_rel_cmd o_cmd,
    input  logic              i_pop
);

    wbu_pkg::t_rel_cmd            r_entry [wbu_pkg::RQ_DEPTH];
    logic [wbu_pkg::RQ_AW-1:0]    r_wr_ptr;
    logic [wbu_pkg::RQ_AW-1:0]    r_rd_ptr;
    logic [wbu_pkg::RQ_AW:0]      r_fill;

    assign o_full  = (r_fill == (wbu_pkg::RQ_AW + 1)'(wbu_pkg::RQ_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: sv/wbu_back.sv
// Back end: holds the waiting warp records and walks them out on release.
module wbu_back #(
    parameter int NUM_BARRIERS = 8,
    parameter int NUM_WARPS    = 8,
    parameter int NUM_LANES    = 8,
    parameter int PC_BITS      = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wbu_pkg::t_slot_wr               i_wr,
    input  logic                            i_q_valid,
    input  wbu_pkg::t_rel_cmd               i_q_cmd,
    output logic                            o_q_pop,
    output wbu_pkg::t_rel_done              o_done,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wbu_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int BAR_LIM = 1 << wbu_pkg::BAR_ID_W;
    localparam int BAR_N   = (NUM_BARRIERS < BAR_LIM) ? NUM_BARRIERS : BAR_LIM;
    localparam int BAR_AW  = (BAR_N > 1) ? $clog2(BAR_N) : 1;
    localparam int CNT_W   = $clog2(NUM_WARPS);
    localparam int LANE_N  = (NUM_LANES < wbu_pkg::MASK_FIELD_W) ? NUM_LANES
                                                                  : wbu_pkg::MASK_FIELD_W;
    localparam int PC_N    = (PC_BITS < wbu_pkg::PC_FIELD_W) ? PC_BITS : wbu_pkg::PC_FIELD_W;
    localparam int ADDR_W  = BAR_AW + CNT_W;
    localparam int MEM_D   = 1 << ADDR_W;
    localparam int WORD_W  = wbu_pkg::WARP_W + PC_N + LANE_N;

    logic [WORD_W-1:0]            r_ram [MEM_D];
    logic [WORD_W-1:0]            r_rd_word;
    wbu_pkg::t_back_state         r_state;
    wbu_pkg::t_back_state         n_state;
    logic [wbu_pkg::BAR_ID_W-1:0] r_bar;
    logic [CNT_W-1:0]             r_slot;
    logic [CNT_W-1:0]             r_last_slot;

    logic                         rd_en;
    logic                         beat;
    logic                         is_last;
    wbu_pkg::t_warp_rec           out_rec;

    assign is_last = (r_slot == r_last_slot);

    // Warp record store: front end writes, release walk reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ram[{i_wr.bar[BAR_AW-1:0], i_wr.slot[CNT_W-1:0]}] <=
                {i_wr.rec.released_mask[LANE_N-1:0],
                 i_wr.rec.released_pc[PC_N-1:0],
                 i_wr.rec.released_warp};
        end
        if (rd_en) begin
            r_rd_word <= r_ram[{r_bar[BAR_AW-1:0], r_slot}];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wbu_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = wbu_pkg::BK_READ;
                end
            end
            wbu_pkg::BK_READ: begin
                n_state = wbu_pkg::BK_SEND;
            end
            wbu_pkg::BK_SEND: begin
                if (i_m_tready) begin
                    n_state = is_last ? wbu_pkg::BK_IDLE : wbu_pkg::BK_READ;
                end
            end
            default: begin
                n_state = wbu_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop    = 1'b0;
        rd_en      = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            wbu_pkg::BK_IDLE: o_q_pop    = i_q_valid;
            wbu_pkg::BK_READ: rd_en      = 1'b1;
            wbu_pkg::BK_SEND: o_m_tvalid = 1'b1;
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
        beat       = o_m_tvalid && i_m_tready;
        o_done.en  = beat && is_last;
        o_done.bar = r_bar;
    end

    // Output beat from the registered read word
    always_comb begin
        out_rec.released_warp = r_rd_word[wbu_pkg::WARP_W-1:0];
        out_rec.released_pc   = wbu_pkg::PC_FIELD_W'(r_rd_word[wbu_pkg::WARP_W +: PC_N]);
        out_rec.released_mask =
            wbu_pkg::MASK_FIELD_W'(r_rd_word[wbu_pkg::WARP_W + PC_N +: LANE_N]);
    end

    assign o_m_tdata = wbu_pkg::OUT_TDATA_W'(out_rec);
    assign o_m_tlast = is_last;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbu_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk position
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bar       <= i_q_cmd.bar;
            r_last_slot <= i_q_cmd.last_slot[CNT_W-1:0];
            r_slot      <= '0;
        end else if (beat && !is_last) begin
            r_slot <= r_slot + 1'b1;
        end
    end

endmodule

// File: sv/warp_barrier_unit.sv
// Top level of the warp barrier unit: front end, release queue and back end.
//
// Each input beat is a warp arriving at a barrier. An arrival whose active and
// predicate masks share no lane, or whose barrier number is out of range, is
// dropped. Otherwise the warp's id, pc and active mask are stored in the next
// slot of its barrier; when the barrier's expected count is met, every stored
// warp of it leaves on the output in slot order with tlast on the final one.
// An arrival beat is taken every cycle while the front end is free; it waits
// in the front end's input register while its barrier still has a release in
// flight, or while it would fill its barrier and the two-entry release queue
// is full. Releases are walked by the back end from a record store holding
// NUM_WARPS slots per barrier with one registered read port: it takes a
// release job while idle, then per released warp reads the store and holds
// the output beat until the sink takes it. The store needs no clearing after reset.
module warp_barrier_unit #(
    parameter int NUM_BARRIERS = 8,
    parameter int NUM_WARPS    = 8,
    parameter int NUM_LANES    = 8,
    parameter int PC_BITS      = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // barrier_id[2:0], expected_count[6:3], warp_number[9:7], warp_pc[41:10],
    // active_mask[49:42], predicate_mask[57:50], zero pad
    input  logic [wbu_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // released_warp[2:0], released_pc[34:3], released_mask[42:35], zero pad
    output logic [wbu_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    wbu_pkg::t_slot_wr  slot_wr;
    wbu_pkg::t_rel_cmd  push_cmd;
    wbu_pkg::t_rel_cmd  q_cmd;
    wbu_pkg::t_rel_done rel_done;
    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;

    wbu_front #(
        .NUM_BARRIERS (NUM_BARRIERS),
        .NUM_WARPS    (NUM_WARPS),
        .NUM_LANES    (NUM_LANES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .o_wr       (slot_wr),
        .o_push     (push),
        .o_push_cmd (push_cmd),
        .i_q_full   (q_full),
        .i_done     (rel_done)
    );

    wbu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    wbu_back #(
        .NUM_BARRIERS (NUM_BARRIERS),
        .NUM_WARPS    (NUM_WARPS),
        .NUM_LANES    (NUM_LANES),
        .PC_BITS      (PC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (slot_wr),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_done     (rel_done),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

// File: test/tb_warp_barrier_unit.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the warp barrier unit, with its own barrier predictor.
module tb_warp_barrier_unit;

    localparam int N_BAR        = 8;
    localparam int N_WARP       = 8;
    localparam int RANDOM_ITEMS = 306;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // One released warp as it should leave the block
    typedef struct {
        wbu_pkg::t_warp_rec rec;
        logic               last;
    } t_release;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // barrier_id, expected_count, warp_number, warp_pc, active_mask, predicate_mask
    logic [wbu_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // released_warp, released_pc, released_mask
    logic [wbu_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    wbu_pkg::t_in_item pending_arrivals[$];
    t_release          expected_releases[$];
    int                total_items    = 0;
    int                n_sent         = 0;
    int                n_accepted     = 0;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    // Predictor copy of the barrier table
    bit                 bar_busy[N_BAR];
    logic [2:0]         bar_count[N_BAR];
    wbu_pkg::t_warp_rec bar_slot[N_BAR][N_WARP];

    always #5 clk = ~clk;

    warp_barrier_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // Idle rates per phase: receiver slow first, then sender slow, then full rate
    function automatic int sender_idle_pct();
        if (n_sent * 3 < total_items)
            return 29;
        if (n_sent * 3 < 2 * total_items)
            return 85;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_sent * 3 < total_items)
            return 85;
        if (n_sent * 3 < 2 * total_items)
            return 29;
        return 0;
    endfunction

    task automatic queue_arrival(input int bar, input int cnt, input int warp,
                                 input logic [31:0] pc, input logic [7:0] act,
                                 input logic [7:0] pred);
        wbu_pkg::t_in_item it;
        it.barrier_id     = bar[wbu_pkg::BAR_ID_W-1:0];
        it.expected_count = cnt[wbu_pkg::EXP_W-1:0];
        it.warp_number    = warp[wbu_pkg::WARP_W-1:0];
        it.warp_pc        = pc;
        it.active_mask    = act;
        it.predicate_mask = pred;
        pending_arrivals.push_back(it);
    endtask

    // Store the arriving warp and, when its barrier fills, queue every stored warp
    task automatic predict_arrival(input wbu_pkg::t_in_item it);
        int         b;
        logic [2:0] c;
        logic       fill;
        t_release   rel;
        b = int'(it.barrier_id);
        if ((it.active_mask & it.predicate_mask) == '0)
            return;
        c = bar_busy[b] ? bar_count[b] : 3'd0;
        bar_slot[b][c].released_warp = it.warp_number;
        bar_slot[b][c].released_pc   = it.warp_pc;
        bar_slot[b][c].released_mask = it.active_mask;
        fill = (it.expected_count == 4'd1) ||
               (it.expected_count != 4'd0 && {1'b0, c} == it.expected_count - 4'd1);
        if (!fill) begin
            bar_busy[b]  = 1'b1;
            bar_count[b] = c + 3'd1;
            return;
        end
        for (int k = 0; k <= int'(c); k++) begin
            rel.rec  = bar_slot[b][k];
            rel.last = (k == int'(c));
            expected_releases.push_back(rel);
        end
        bar_busy[b]  = 1'b0;
        bar_count[b] = 3'd0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch, %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // Sender: hold each beat until taken, idle at random between beats
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_arrival(wbu_pkg::t_in_item'(s_tdata[wbu_pkg::IN_FIELDS_W-1:0]));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_arrivals.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    s_tdata  <= {{(wbu_pkg::IN_TDATA_W-wbu_pkg::IN_FIELDS_W){1'b0}},
                                 pending_arrivals.pop_front()};
                    s_tvalid <= 1'b1;
                    n_sent++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken beat against the oldest expected release
    always @(posedge clk) begin
        wbu_pkg::t_warp_rec got;
        t_release           want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = wbu_pkg::t_warp_rec'(m_tdata[wbu_pkg::OUT_FIELDS_W-1:0]);
                if (expected_releases.size() == 0) begin
                    report_mismatch("beat with nothing expected", 32'(got.released_warp), '0);
                end else begin
                    want = expected_releases.pop_front();
                    if (got.released_warp !== want.rec.released_warp)
                        report_mismatch("released_warp", 32'(got.released_warp),
                                        32'(want.rec.released_warp));
                    if (got.released_pc !== want.rec.released_pc)
                        report_mismatch("released_pc", got.released_pc, want.rec.released_pc);
                    if (got.released_mask !== want.rec.released_mask)
                        report_mismatch("released_mask", 32'(got.released_mask),
                                        32'(want.rec.released_mask));
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", 32'(m_tlast), 32'(want.last));
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_warp_barrier_unit: done, errors");
            $finish;
        end
    end

    initial begin
        int          b;
        int          r;
        int          cnt;
        int          plan_zero[N_BAR];
        int          plan_left[N_BAR];
        int          plan_n[N_BAR];
        logic [7:0]  act;
        logic [7:0]  pred;
        logic [31:0] pc;

        // Dropped arrivals: no predicate at all, then no shared lane
        queue_arrival(0, 1, 2, 32'h1234_5678, 8'hFF, 8'h00);
        queue_arrival(0, 1, 3, 32'h8765_4321, 8'h0F, 8'hF0);
        // Count of one on an empty barrier releases at once
        queue_arrival(0, 1, 7, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        // Plain count of three with extreme pcs and masks
        queue_arrival(2, 3, 0, 32'h0000_0000, 8'h01, 8'h01);
        queue_arrival(2, 3, 5, 32'hA5A5_A5A5, 8'h80, 8'h80);
        queue_arrival(2, 3, 3, 32'h5A5A_5A5A, 8'hFF, 8'h01);
        // Zero count never fills; a later count of one flushes the stored warps too
        queue_arrival(5, 0, 1, 32'h0000_0010, 8'h3C, 8'h04);
        queue_arrival(5, 0, 6, 32'h0000_0020, 8'hC3, 8'h40);
        queue_arrival(5, 1, 4, 32'h0000_0030, 8'h55, 8'hAA | 8'h01);
        // Full barrier: eight warps, the largest release
        for (int w = 0; w < 7; w++)
            queue_arrival(7, 0, w, $urandom, 8'hFF, 8'hFF);
        queue_arrival(7, 8, 7, $urandom, 8'hFE, 8'h02);
        // Counts that disagree between arrivals: the later, smaller one fills
        queue_arrival(3, 4, 2, $urandom, 8'h11, 8'h10);
        queue_arrival(3, 2, 6, $urandom, 8'h22, 8'h20);
        // Two barriers filling interleaved
        queue_arrival(1, 2, 0, $urandom, 8'h0F, 8'h0F);
        queue_arrival(6, 2, 1, $urandom, 8'hF0, 8'hF0);
        queue_arrival(1, 2, 2, $urandom, 8'h33, 8'h03);
        queue_arrival(6, 2, 3, $urandom, 8'hCC, 8'h0C);

        // Random part: mostly planned barrier fills, some dropped and stray arrivals
        for (int i = 0; i < N_BAR; i++) begin
            plan_zero[i] = 0;
            plan_left[i] = 0;
            plan_n[i]    = 0;
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            b = $urandom_range(N_BAR - 1);
            r = $urandom_range(99);
            r = (r < 10) ? 0 : r;
            pc = $urandom;
            if ($urandom_range(9) == 0)
                pc = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            act  = ($urandom_range(19) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            pred = 8'($urandom_range(255)) | (act & (~act + 8'd1));
            if (r < 80) begin
                if (plan_zero[b] == 0 && plan_left[b] == 0) begin
                    if ($urandom_range(9) == 0) begin
                        // Overrun: wrap the slot ring, then fill on the wrapped count
                        plan_zero[b] = $urandom_range(9, 12);
                        plan_left[b] = 1;
                        plan_n[b]    = plan_zero[b] % N_WARP + 1;
                    end else begin
                        plan_n[b]    = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
                        plan_left[b] = plan_n[b];
                    end
                end
                if (plan_zero[b] > 0) begin
                    cnt = 0;
                    plan_zero[b]--;
                end else begin
                    cnt = plan_n[b];
                    plan_left[b]--;
                end
                queue_arrival(b, cnt, $urandom_range(7), pc, act, pred);
            end else if (r < 90) begin
                // No shared lane: dropped
                act  = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(255));
                pred = 8'($urandom_range(255)) & ~act;
                queue_arrival(b, $urandom_range(8), $urandom_range(7), pc, act, pred);
            end else begin
                // Stray arrival with any count
                queue_arrival(b, $urandom_range(8), $urandom_range(7), pc, act, pred);
            end
        end
        total_items = pending_arrivals.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < total_items)
            @(posedge clk);
        while (expected_releases.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_warp_barrier_unit: done, clean");
        else
            $display("tb_warp_barrier_unit: done, errors");
        $finish;
    end

endmodule
